[rtl/core/shared_exclusive_lock_table_core_macros.svh]
// ----------------------------------------------------------------------------
// Shared/exclusive lock table assertion macros
// Short forms for the concurrent checks used inside the lock table modules.
// ----------------------------------------------------------------------------
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_CORE_MACROS_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SELT_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: lock table check failed");

// A condition that must be followed by another one on the next edge.
`define SELT_ASSERT_NEXT(name, cond, nxt) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error("%m: lock table sequence check failed");

`endif

[rtl/core/selt_pkg.sv]
// ----------------------------------------------------------------------------
// Shared/exclusive lock table package
// Field widths, request and reply codes, and the queued request word.
// ----------------------------------------------------------------------------
package selt_pkg;

	localparam int LOCK_SLOTS_DEF  = 1024;
	localparam int TABLES_DEF      = 2;
	localparam int LOG_ENTRIES_DEF = 1024;
	localparam int COUNT_BITS_DEF  = 16;

	localparam int FUNC_W     = 3;
	localparam int TSEL_W     = 1;
	localparam int SLOT_W     = 10;
	localparam int REPLY_W    = 4;
	localparam int HOLD_W     = 16;
	localparam int LOG_SLOT_W = 10;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [FUNC_W-1:0] FUNC_ACQ_SH      = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ACQ_EX      = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_REL_SH      = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_REL_EX      = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_COMMIT_PRIM = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_COMMIT_BCK  = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_COMMIT_LOG  = 3'd6;

	typedef enum logic [2:0] {
		OP_ACQ_SH,
		OP_ACQ_EX,
		OP_REL_SH,
		OP_REL_EX,
		OP_COMMIT_PRIM,
		OP_COMMIT_BCK,
		OP_COMMIT_LOG,
		OP_BAD
	} op_t;

	typedef enum logic [REPLY_W-1:0] {
		RPL_GRANT_SH  = 4'd0,
		RPL_REJECT_SH = 4'd1,
		RPL_GRANT_EX  = 4'd2,
		RPL_REJECT_EX = 4'd3,
		RPL_REL_SH    = 4'd4,
		RPL_REL_EX    = 4'd5,
		RPL_PRIM      = 4'd6,
		RPL_BCK       = 4'd7,
		RPL_LOG       = 4'd8,
		RPL_ERROR     = 4'd9
	} reply_t;

	typedef struct packed {
		op_t               op;
		logic              in_range;
		logic [TSEL_W-1:0] tsel;
		logic [SLOT_W-1:0] slot;
	} item_t;

endpackage

[rtl/core/selt_ram.sv]
// ----------------------------------------------------------------------------
// Lock table RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module selt_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/selt_front.sv]
// ----------------------------------------------------------------------------
// Lock table front end
// Accepts requests, decodes the request code, checks the table and slot
// range, and holds the classified words in a two-entry queue.
// ----------------------------------------------------------------------------
`include "shared_exclusive_lock_table_core_macros.svh"

module selt_front
	import selt_pkg::*;
#(
	parameter int LOCK_SLOTS = LOCK_SLOTS_DEF,
	parameter int TABLES     = TABLES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FUNC_W-1:0] func,
	input  logic [TSEL_W-1:0] table_sel,
	input  logic [SLOT_W-1:0] lock_slot,
	input  logic              clearing,
	input  logic              pop,
	output logic              busy,
	output logic              head_valid,
	output item_t             head
);

	item_t             queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	item_t             item;

	always_comb begin
		case (func)
			FUNC_ACQ_SH:      item.op = OP_ACQ_SH;
			FUNC_ACQ_EX:      item.op = OP_ACQ_EX;
			FUNC_REL_SH:      item.op = OP_REL_SH;
			FUNC_REL_EX:      item.op = OP_REL_EX;
			FUNC_COMMIT_PRIM: item.op = OP_COMMIT_PRIM;
			FUNC_COMMIT_BCK:  item.op = OP_COMMIT_BCK;
			FUNC_COMMIT_LOG:  item.op = OP_COMMIT_LOG;
			default:          item.op = OP_BAD;
		endcase
		item.in_range = (32'(table_sel) < 32'(TABLES)) && (32'(lock_slot) < 32'(LOCK_SLOTS));
		item.tsel     = table_sel;
		item.slot     = lock_slot;
	end

	assign busy       = clearing || (cnt_q == QCNT_W'(QDEPTH));
	assign push       = start && !busy;
	assign head_valid = (cnt_q != '0);
	assign head       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`SELT_ASSERT(a_pop_needs_word, pop |-> head_valid)
	`SELT_ASSERT_NEXT(a_last_pop_empties, cnt_q == 2'd1 && pop && !push, !head_valid)

endmodule

[rtl/core/selt_back.sv]
// ----------------------------------------------------------------------------
// Lock table back end
// Clears the table after reset, then for each queued request reads the
// addressed slot and writes it back when the lock state changes, keeps the log
// position, and drives the registered result ports.
// ----------------------------------------------------------------------------
`include "shared_exclusive_lock_table_core_macros.svh"

module selt_back
	import selt_pkg::*;
#(
	parameter int LOCK_SLOTS  = LOCK_SLOTS_DEF,
	parameter int TABLES      = TABLES_DEF,
	parameter int LOG_ENTRIES = LOG_ENTRIES_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  item_t                 head,
	output logic                  pop,
	output logic                  clearing,
	output logic                  done,
	output logic [REPLY_W-1:0]    reply,
	output logic [TSEL_W-1:0]     table_echo,
	output logic [SLOT_W-1:0]     slot_echo,
	output logic [HOLD_W-1:0]     shared_holders,
	output logic                  exclusive_owned,
	output logic [LOG_SLOT_W-1:0] log_slot
);

	localparam int ENTRIES = TABLES * LOCK_SLOTS;
	localparam int AW      = $clog2(ENTRIES);
	localparam int LW      = $clog2(LOG_ENTRIES);
	localparam int WIDTH   = COUNT_BITS + 1;

	logic                  clearing_q;
	logic [AW-1:0]         clr_addr_q;
	logic [LW-1:0]         log_pos_q;

	logic                  valid_s1;
	item_t                 item_s1;
	logic [AW-1:0]         addr_s1;

	logic                  done_q;
	reply_t                reply_q;
	logic [TSEL_W-1:0]     table_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [HOLD_W-1:0]     holders_q;
	logic                  excl_q;
	logic [LOG_SLOT_W-1:0] log_slot_q;

	logic [31:0]           idx_w;
	logic [AW-1:0]         raddr;
	logic [WIDTH-1:0]      rdata;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [WIDTH-1:0]      wdata;

	logic [COUNT_BITS-1:0] cnt;
	logic                  ex;
	logic [COUNT_BITS-1:0] new_cnt;
	logic                  new_ex;
	logic                  upd;
	logic                  log_adv;
	reply_t                rpl;
	logic [31:0]           cnt_w;
	logic [31:0]           log_w;

	assign pop      = head_valid && !clearing_q && !valid_s1;
	assign clearing = clearing_q;

	always_comb begin
		idx_w = ((head.tsel != '0) ? 32'(LOCK_SLOTS) : 32'd0) + 32'(head.slot);
		raddr = head.in_range ? idx_w[AW-1:0] : '0;
	end

	always_comb begin
		cnt     = rdata[COUNT_BITS-1:0];
		ex      = rdata[COUNT_BITS];
		new_cnt = cnt;
		new_ex  = ex;
		upd     = 1'b0;
		log_adv = 1'b0;
		rpl     = RPL_ERROR;
		case (item_s1.op)
			OP_ACQ_SH: begin
				if (item_s1.in_range) begin
					if (!ex && !(&cnt)) begin
						new_cnt = cnt + 1'b1;
						upd     = 1'b1;
						rpl     = RPL_GRANT_SH;
					end else begin
						rpl = RPL_REJECT_SH;
					end
				end
			end
			OP_ACQ_EX: begin
				if (item_s1.in_range) begin
					if (!ex && (cnt == '0)) begin
						new_ex = 1'b1;
						upd    = 1'b1;
						rpl    = RPL_GRANT_EX;
					end else begin
						rpl = RPL_REJECT_EX;
					end
				end
			end
			OP_REL_SH: begin
				if (item_s1.in_range && (cnt != '0)) begin
					new_cnt = cnt - 1'b1;
					upd     = 1'b1;
					rpl     = RPL_REL_SH;
				end
			end
			OP_REL_EX: begin
				if (item_s1.in_range && ex) begin
					new_ex = 1'b0;
					upd    = 1'b1;
					rpl    = RPL_REL_EX;
				end
			end
			OP_COMMIT_PRIM: rpl = RPL_PRIM;
			OP_COMMIT_BCK:  rpl = RPL_BCK;
			OP_COMMIT_LOG: begin
				log_adv = 1'b1;
				rpl     = RPL_LOG;
			end
			default: rpl = RPL_ERROR;
		endcase
		cnt_w = item_s1.in_range ? 32'(new_cnt) : 32'd0;
		log_w = log_adv ? 32'(log_pos_q) : 32'd0;
	end

	always_comb begin
		we    = clearing_q || (valid_s1 && upd);
		waddr = clearing_q ? clr_addr_q : addr_s1;
		wdata = clearing_q ? '0 : {new_ex, new_cnt};
	end

	selt_ram #(
		.WIDTH (WIDTH),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (pop),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head;
			addr_s1 <= raddr;
		end
		if (valid_s1) begin
			reply_q    <= rpl;
			table_q    <= item_s1.tsel;
			slot_q     <= item_s1.slot;
			holders_q  <= cnt_w[HOLD_W-1:0];
			excl_q     <= item_s1.in_range && new_ex;
			log_slot_q <= log_w[LOG_SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			log_pos_q  <= '0;
			valid_s1   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_addr_q == AW'(ENTRIES - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			if (valid_s1 && log_adv) begin
				if (log_pos_q == LW'(LOG_ENTRIES - 1)) begin
					log_pos_q <= '0;
				end else begin
					log_pos_q <= log_pos_q + 1'b1;
				end
			end
			valid_s1 <= pop;
			done_q   <= valid_s1;
		end
	end

	assign done            = done_q;
	assign reply           = reply_q;
	assign table_echo      = table_q;
	assign slot_echo       = slot_q;
	assign shared_holders  = holders_q;
	assign exclusive_owned = excl_q;
	assign log_slot        = log_slot_q;

	`SELT_ASSERT(a_no_update_while_clearing, valid_s1 |-> !clearing_q)
	`SELT_ASSERT_NEXT(a_done_spaced, done_q, !done_q)
	`SELT_ASSERT(a_grant_ex_state, done_q && reply_q == RPL_GRANT_EX |-> excl_q && holders_q == '0)

endmodule

[rtl/core/shared_exclusive_lock_table_core.sv]
// ----------------------------------------------------------------------------
// Shared/exclusive lock table core
// done strobes each result once the request has passed the queue, RAM read and result registers.
// For each request the back end does a table RAM read, then the update and write-back.
// It takes no new request until the last one is updated; a two-word queue absorbs bursts.
// After reset the table RAM is cleared one entry per cycle, all TABLES*LOCK_SLOTS entries
// (2048 at the defaults), with busy high; the log position resets to zero.
// ----------------------------------------------------------------------------
module shared_exclusive_lock_table_core
	import selt_pkg::*;
#(
	parameter int LOCK_SLOTS  = LOCK_SLOTS_DEF,
	parameter int TABLES      = TABLES_DEF,
	parameter int LOG_ENTRIES = LOG_ENTRIES_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [FUNC_W-1:0]     func,
	input  logic [TSEL_W-1:0]     table_sel,
	input  logic [SLOT_W-1:0]     lock_slot,
	output logic                  busy,
	output logic                  done,
	output logic [REPLY_W-1:0]    reply,
	output logic [TSEL_W-1:0]     table_echo,
	output logic [SLOT_W-1:0]     slot_echo,
	output logic [HOLD_W-1:0]     shared_holders,
	output logic                  exclusive_owned,
	output logic [LOG_SLOT_W-1:0] log_slot
);

	logic  clearing;
	logic  pop;
	logic  head_valid;
	item_t head;

	selt_front #(
		.LOCK_SLOTS (LOCK_SLOTS),
		.TABLES     (TABLES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.func       (func),
		.table_sel  (table_sel),
		.lock_slot  (lock_slot),
		.clearing   (clearing),
		.pop        (pop),
		.busy       (busy),
		.head_valid (head_valid),
		.head       (head)
	);

	selt_back #(
		.LOCK_SLOTS  (LOCK_SLOTS),
		.TABLES      (TABLES),
		.LOG_ENTRIES (LOG_ENTRIES),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head            (head),
		.pop             (pop),
		.clearing        (clearing),
		.done            (done),
		.reply           (reply),
		.table_echo      (table_echo),
		.slot_echo       (slot_echo),
		.shared_holders  (shared_holders),
		.exclusive_owned (exclusive_owned),
		.log_slot        (log_slot)
	);

endmodule
